FILE: hw/rtl/utf16v_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 stream validator package
// Shared constants and the per-buffer state record of the validator.
// ----------------------------------------------------------------------------
package utf16v_pkg;

   localparam logic [15:0] LeadLo      = 16'hd800;
   localparam logic [15:0] LeadHi      = 16'hdbff;
   localparam logic [15:0] TrailLo     = 16'hdc00;
   localparam logic [15:0] TrailHi     = 16'hdfff;
   localparam logic [15:0] TrailPe     = 16'hdffe;
   localparam logic [15:0] NoncharA    = 16'hfffe;
   localparam logic [15:0] NoncharB    = 16'hffff;
   localparam logic [15:0] NcRangeLo   = 16'hfdd0;
   localparam logic [15:0] NcRangeHi   = 16'hfdef;
   localparam logic [5:0]  LeadPeMask  = 6'h3f;

   localparam logic ByteOrderLittle = 1'b0;
   localparam logic ByteOrderBig    = 1'b1;

   // State carried from one beat of a buffer to the next.
   typedef struct packed {
      logic       half_unit_held;
      logic [7:0] held_byte;
      logic       lead_waiting;
      logic       lead_plane_end;
      logic       zero_unit_pending;
      logic       failed;
   } buf_state_type;

   localparam buf_state_type BufStateClear = '{
      half_unit_held:    1'b0,
      held_byte:         8'h00,
      lead_waiting:      1'b0,
      lead_plane_end:    1'b0,
      zero_unit_pending: 1'b0,
      failed:            1'b0
   };

endpackage

FILE: hw/rtl/utf16v_unit_check.sv
// ----------------------------------------------------------------------------
// UTF-16 unit checker
// Combinational next-state and verdict logic for one byte of a buffer.
// ----------------------------------------------------------------------------
module utf16v_unit_check (
   input  utf16v_pkg::buf_state_type state_cur,
   input  logic [7:0]                data_byte,
   input  logic                      last,
   input  logic                      byte_order,
   output utf16v_pkg::buf_state_type state_nxt,
   output logic                      verdict
);
   import utf16v_pkg::*;

   logic [15:0]   unit;
   buf_state_type st;

   always_comb begin
      unit = (byte_order == ByteOrderBig) ? {state_cur.held_byte, data_byte}
                                          : {data_byte, state_cur.held_byte};
      st = state_cur;

      if (state_cur.half_unit_held) begin
         st.half_unit_held = 1'b0;
         if (state_cur.lead_waiting) begin
            // The unit after a lead must be a trail, and must not close a
            // plane-end noncharacter.
            st.lead_waiting = 1'b0;
            if (!(unit inside {[TrailLo:TrailHi]})) begin
               st.failed = 1'b1;
            end else if (state_cur.lead_plane_end && unit >= TrailPe) begin
               st.failed = 1'b1;
            end
            st.lead_plane_end = 1'b0;
         end else begin
            if (state_cur.zero_unit_pending) begin
               st.failed            = 1'b1;
               st.zero_unit_pending = 1'b0;
            end
            if (unit == 16'h0000) begin
               st.zero_unit_pending = 1'b1;
            end else if (unit inside {[LeadLo:LeadHi]}) begin
               st.lead_waiting   = 1'b1;
               st.lead_plane_end = (unit[5:0] == LeadPeMask);
            end else if (unit inside {[TrailLo:TrailHi]}) begin
               st.failed = 1'b1;
            end else if (unit inside {NoncharA, NoncharB, [NcRangeLo:NcRangeHi]}) begin
               st.failed = 1'b1;
            end
         end
      end else if (!last) begin
         st.held_byte      = data_byte;
         st.half_unit_held = 1'b1;
      end

      verdict   = !st.failed && !st.lead_waiting;
      state_nxt = last ? BufStateClear : st;
   end

endmodule

FILE: hw/rtl/utf16_stream_validator_top.sv
// ----------------------------------------------------------------------------
// UTF-16 stream validator
// Checks a byte stream, one buffer at a time, for well-formed UTF-16 and
// returns one verdict beat per buffer.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                              | Direction | Carries
//   --------+------------------------------------+-----------+----------------------
//   req     | req_valid req_stall req_data_byte  | in        | one byte per beat,
//           | req_last                           |           | last marks buffer end
//   rsp     | rsp_valid rsp_stall rsp_valid_res  | out       | one verdict per buffer
//   csr     | csr_wr_en csr_wr_data              | in        | byte order register
//
// One byte is taken every cycle unless the input side is stalled. Each byte
// is captured in the input register, where the unit checker updates the
// buffer state; the verdict of a last beat is then registered in the result
// register, which drives the result port. Only a last beat that finds the
// result register still occupied and stalled holds up the input side. Reset
// clears the valid flags and buffer state and sets little-endian byte order;
// no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module utf16_stream_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import utf16v_pkg::*;

   // Input register: holds the beat being worked on.
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;

   // Buffer state and the byte order register.
   buf_state_type state_ff, state_in;
   logic          byte_order_ff;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_res_ff, rsp_res_in;

   logic          verdict;
   logic          out_free;
   logic          advance;
   logic          accept;

   utf16v_unit_check u_unit_check (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .byte_order (byte_order_ff),
      .state_nxt  (state_in),
      .verdict    (verdict)
   );

   // The result register is free when it is empty or is being emptied now.
   // A beat that is not last never needs it, so it always moves on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = verdict;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= BufStateClear;
         byte_order_ff <= ByteOrderLittle;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            byte_order_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

FILE: hw/rtl/utf16v_checker.sv
// ----------------------------------------------------------------------------
// UTF-16 stream validator checker
// Port-level assertions on the validator, bound to the top level.
// ----------------------------------------------------------------------------
module utf16v_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_valid_res
);

   // A stalled verdict stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_valid_res))
      else $error("verdict beat changed while stalled");

   // Reset leaves no verdict pending and the input side open.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // The input side is only held up by a stalled verdict.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the result side is free");

   // A last beat yields its verdict if the result side is free once the beat is in the input register.
   a_last_verdict: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid)
      else $error("verdict missing after last beat");

endmodule

bind utf16_stream_validator_top utf16v_checker u_utf16v_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_valid_res (rsp_valid_res)
);
